// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HeapUnitsDefault = 4096;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] request_bytes;
		logic [14:0] release_offset;
	} req_t;

	typedef struct packed {
		logic [14:0] payload_offset;
		logic        granted;
		logic [15:0] used_bytes;
	} rsp_t;

endpackage

// ===== rtl/ffha_hdr_mem.sv =====
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Header store: one header per unit, size and used flag, registered read.
// ----------------------------------------------------------------------------
module ffha_hdr_mem #(
	parameter int Depth = 4096,
	parameter int Aw    = $clog2(Depth),
	parameter int Dw    = Aw + 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [Aw-1:0] waddr,
	input  logic [Dw-1:0] wdata,
	input  logic [Aw-1:0] raddr,
	output logic [Dw-1:0] rdata
);

	logic [Dw-1:0] mem [Depth];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an implicit list of block headers in 8-byte units.
// ----------------------------------------------------------------------------
// One command is handled at a time. Each command walks the block headers from
// unit 0 through a header memory with one write and one read port, visiting each
// header in two steps (address, then registered read and compare). Every block
// spans at least two units, so a walk visits at most HEAP_UNITS / 2 headers, and
// a command also waits out any stall on the result beat. After reset, unit 0 is
// written once in ST_INIT and no clearing pass is needed.
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int HEAP_UNITS = HeapUnitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	localparam int Aw = $clog2(HEAP_UNITS);
	localparam int Sw = Aw + 2; // room for sums before saturation/compare
	localparam logic [Sw-1:0] SizeMax = Sw'(HEAP_UNITS - 1);
	localparam logic [Sw-1:0] LastHdr = Sw'(HEAP_UNITS - 2);
	localparam logic [Sw-1:0] Units   = Sw'(HEAP_UNITS);

	localparam logic [3:0] ST_INIT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ARD   = 4'd2;
	localparam logic [3:0] ST_ACHK  = 4'd3;
	localparam logic [3:0] ST_ASPL  = 4'd4;
	localparam logic [3:0] ST_RRD   = 4'd5;
	localparam logic [3:0] ST_RCHK  = 4'd6;
	localparam logic [3:0] ST_C0RD  = 4'd7;
	localparam logic [3:0] ST_C0    = 4'd8;
	localparam logic [3:0] ST_CRD   = 4'd9;
	localparam logic [3:0] ST_CCHK  = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;
	localparam logic [3:0] ST_AREM  = 4'd12;

	logic [3:0]    state_q;
	logic [Sw-1:0] n_q, p_q, prev_q, prev_size_q, used_q;
	logic          prev_free_q;
	logic [14:0]   off_q;
	logic          ok_q;

	logic          we;
	logic [Aw-1:0] waddr, raddr;
	logic [Aw:0]   wdata, rdata;
	logic [Sw-1:0] rsize;
	logic          rused;

	ffha_hdr_mem #(.Depth(HEAP_UNITS)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign rsize = Sw'(rdata[Aw-1:0]);
	assign rused = rdata[Aw];

	function automatic logic [Sw-1:0] sat(input logic [Sw-1:0] v);
		return (v > SizeMax) ? SizeMax : v;
	endfunction

	// Shared next-header adder and compare.
	logic [Sw-1:0] nxt_base, nxt_add, nxt;
	logic          beyond;
	assign nxt    = nxt_base + nxt_add + Sw'(1);
	assign beyond = nxt > LastHdr;

	// Saturated header sizes for the granted block and for a merge.
	logic [Sw-1:0] alloc_size, grow_size, merge_size;
	assign alloc_size = sat(n_q);
	assign grow_size  = sat(n_q + Sw'(1));
	assign merge_size = sat(prev_size_q + rsize + Sw'(1));

	logic [Sw-1:0] rel_unit;
	assign rel_unit = Sw'(in_data.release_offset[14:3]);

	always_comb begin
		we = 1'b0;
		waddr = p_q[Aw-1:0];
		wdata = '0;
		raddr = p_q[Aw-1:0];
		nxt_base = p_q;
		nxt_add = rsize;
		case (state_q)
			ST_INIT: begin
				we = 1'b1;
				waddr = '0;
				wdata = {1'b0, SizeMax[Aw-1:0]};
			end
			ST_ACHK: begin
				nxt_base = p_q;
				nxt_add = rsize;
			end
			ST_ASPL: begin
				nxt_base = p_q;
				nxt_add = n_q;
				we = 1'b1;
				if (beyond || (prev_size_q - n_q) < Sw'(2)) begin
					wdata = {1'b1, grow_size[Aw-1:0]};
				end else begin
					wdata = {1'b1, alloc_size[Aw-1:0]};
				end
			end
			// The free remainder after a split gets its own header.
			ST_AREM: begin
				we = 1'b1;
				wdata = {1'b0, prev_size_q[Aw-1:0]};
			end
			ST_RCHK: begin
				we = 1'b1;
				wdata = {1'b0, rdata[Aw-1:0]};
			end
			ST_C0RD: raddr = '0;
			ST_CCHK: begin
				nxt_base = prev_q;
				nxt_add = prev_size_q;
				if (!rused && prev_free_q) begin
					we = 1'b1;
					waddr = prev_q[Aw-1:0];
					wdata = {1'b0, merge_size[Aw-1:0]};
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			used_q      <= Sw'(1);
			n_q         <= '0;
			p_q         <= '0;
			prev_q      <= '0;
			prev_size_q <= '0;
			prev_free_q <= 1'b0;
			off_q       <= '0;
			ok_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: state_q <= ST_IDLE;
				ST_IDLE: if (in_valid) begin
					ok_q  <= 1'b0;
					off_q <= '0;
					p_q   <= '0;
					if (in_data.command == CMD_ALLOC) begin
						n_q <= Sw'((17'(in_data.request_bytes) + 17'd7) >> 3);
						if (in_data.request_bytes == '0 || used_q +
						    Sw'((17'(in_data.request_bytes) + 17'd7) >> 3) > Units) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_ARD;
						end
					end else if (rel_unit == '0 || rel_unit - Sw'(1) >= Units) begin
						state_q <= ST_OUT;
					end else begin
						p_q     <= rel_unit - Sw'(1);
						state_q <= ST_RRD;
					end
				end
				ST_ARD: state_q <= ST_ACHK;
				ST_ACHK: begin
					if (!rused && rsize > n_q + Sw'(1)) begin
						prev_size_q <= rsize;
						state_q     <= ST_ASPL;
					end else if (beyond) begin
						state_q <= ST_OUT;
					end else begin
						p_q     <= nxt;
						state_q <= ST_ARD;
					end
				end
				ST_ASPL: begin
					ok_q  <= 1'b1;
					off_q <= 15'({p_q + Sw'(1), 3'b000});
					used_q <= used_q + n_q + Sw'(1);
					if (beyond || (prev_size_q - n_q) < Sw'(2)) begin
						state_q <= ST_OUT;
					end else begin
						// Remainder header written next cycle.
						p_q         <= nxt;
						prev_size_q <= prev_size_q - n_q - Sw'(1);
						state_q     <= ST_AREM;
					end
				end
				ST_AREM: state_q <= ST_OUT;
				ST_RRD: state_q <= ST_RCHK;
				ST_RCHK: begin
					ok_q    <= 1'b1;
					used_q  <= (rsize >= used_q) ? '0 : used_q - rsize;
					state_q <= ST_C0RD;
				end
				ST_C0RD: state_q <= ST_C0;
				ST_C0: begin
					prev_q      <= '0;
					prev_size_q <= rsize;
					prev_free_q <= !rused;
					p_q         <= rsize + Sw'(1);
					state_q     <= (rsize + Sw'(1) > LastHdr) ? ST_OUT : ST_CRD;
				end
				ST_CRD: state_q <= ST_CCHK;
				ST_CCHK: begin
					if (!rused && prev_free_q) begin
						prev_size_q <= merge_size;
						used_q <= (used_q == '0) ? '0 : used_q - Sw'(1);
						if (merge_size + prev_q + Sw'(1) > LastHdr)
							state_q <= ST_OUT;
						else begin
							p_q     <= merge_size + prev_q + Sw'(1);
							state_q <= ST_CRD;
						end
					end else begin
						prev_free_q <= !rused;
						prev_q      <= p_q;
						prev_size_q <= rsize;
						if (p_q + rsize + Sw'(1) > LastHdr)
							state_q <= ST_OUT;
						else begin
							p_q     <= p_q + rsize + Sw'(1);
							state_q <= ST_CRD;
						end
					end
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result beat, taken straight from the result registers.
	always_comb begin
		out_data.payload_offset = off_q;
		out_data.granted        = ok_q;
		out_data.used_bytes     = 16'({used_q, 3'b000});
	end

endmodule

// ===== sim/first_fit_heap_allocator_test.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_test
// Self-checking bench for the first-fit heap allocator.
// ----------------------------------------------------------------------------
// A queue of commands is filled up front. A clocked driver feeds it to the
// block, and a clocked monitor checks every reply beat against a heap model
// that tracks block headers and the used count. Releases marked "live" get
// their offset at drive time, picked from the blocks the model holds as
// allocated, so that no header that was never written is ever read.
module first_fit_heap_allocator_test
	import ffha_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Units = HeapUnitsDefault;
	localparam int LastHeader = Units - 2;
	localparam int SizeCap = Units - 1;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;

	first_fit_heap_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Heap model state.
	int unsigned blk_size [Units];
	bit blk_used [Units];
	int unsigned used_units;
	int unsigned live_offsets [$];

	req_t pending_cmds [$];
	bit pending_live [$];
	rsp_t awaited_replies [$];
	int unsigned accepted_cmds;
	int unsigned mismatches;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned cap_size(longint unsigned v);
		return (v > SizeCap) ? SizeCap : int'(v);
	endfunction

	function automatic void drop_used(longint unsigned v);
		used_units = (v >= used_units) ? 0 : used_units - int'(v);
	endfunction

	// Merge every run of adjacent free blocks, walking from unit 0.
	function automatic void merge_free_runs();
		longint unsigned prev, nxt;
		bit prev_free;
		prev = 0;
		prev_free = !blk_used[0];
		forever begin
			nxt = prev + 1 + blk_size[prev];
			if (nxt > LastHeader)
				break;
			if (!blk_used[nxt] && prev_free) begin
				blk_size[prev] = cap_size(longint'(blk_size[prev]) + blk_size[nxt] + 1);
				drop_used(1);
			end else begin
				prev_free = !blk_used[nxt];
				prev = nxt;
			end
		end
	endfunction

	// Apply one command to the heap model and return the reply it must give.
	function automatic rsp_t heap_apply(req_t cmd);
		rsp_t rsp;
		longint unsigned n, p, orig, nxt, h;
		bit ok;
		rsp = '0;
		ok = 1'b0;
		if (cmd.command == CMD_ALLOC) begin
			n = (longint'(cmd.request_bytes) + 7) >> 3;
			p = 0;
			if (n != 0 && used_units + n <= Units) begin
				ok = 1'b1;
				while (blk_used[p] || blk_size[p] <= n + 1) begin
					p = p + 1 + blk_size[p];
					if (p > LastHeader) begin
						ok = 1'b0;
						break;
					end
				end
			end
			if (ok) begin
				orig = blk_size[p];
				blk_size[p] = cap_size(n);
				blk_used[p] = 1'b1;
				used_units += int'(n) + 1;
				nxt = p + 1 + n;
				if (nxt > LastHeader || orig - n < 2) begin
					// Tail absorb: the block takes the spare unit.
					blk_size[p] = cap_size(longint'(blk_size[p]) + 1);
				end else begin
					blk_size[nxt] = cap_size(orig - n - 1);
					blk_used[nxt] = 1'b0;
				end
				rsp.payload_offset = 15'((p + 1) * 8);
				live_offsets.push_back(int'((p + 1) * 8));
			end
		end else begin
			h = longint'(cmd.release_offset) >> 3;
			if (h != 0 && h - 1 < Units) begin
				h = h - 1;
				ok = 1'b1;
				blk_used[h] = 1'b0;
				drop_used(blk_size[h]);
				merge_free_runs();
				foreach (live_offsets[i])
					if (live_offsets[i] == cmd.release_offset) begin
						live_offsets.delete(i);
						break;
					end
			end
		end
		rsp.granted = ok;
		rsp.used_bytes = 16'(used_units * 8);
		return rsp;
	endfunction

	function automatic bit side_idles();
		if (accepted_cmds >= 70 && accepted_cmds < 100)
			return 1'b0;
		return $urandom_range(99) < 36;
	endfunction

	// Driver: predict each accepted beat, then load the next command.
	always @(posedge clk or negedge arst_n) begin
		req_t nxt_cmd;
		bit live;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				awaited_replies.push_back(heap_apply(in_data));
				accepted_cmds++;
			end
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() != 0 && !side_idles()) begin
					nxt_cmd = pending_cmds.pop_front();
					live = pending_live.pop_front();
					if (live)
						nxt_cmd.release_offset = (live_offsets.size() == 0) ? 15'd0 :
							15'(live_offsets[$urandom_range(live_offsets.size() - 1)]);
					in_data <= nxt_cmd;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each reply beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_replies.size() == 0) begin
					$error("unexpected reply beat: %p", out_data);
					mismatches++;
				end else begin
					want = awaited_replies.pop_front();
					if (out_data.payload_offset !== want.payload_offset) begin
						$error("payload_offset expected %0d actual %0d",
							want.payload_offset, out_data.payload_offset);
						mismatches++;
					end
					if (out_data.granted !== want.granted) begin
						$error("granted expected %0d actual %0d", want.granted, out_data.granted);
						mismatches++;
					end
					if (out_data.used_bytes !== want.used_bytes) begin
						$error("used_bytes expected %0d actual %0d",
							want.used_bytes, out_data.used_bytes);
						mismatches++;
					end
				end
			end
			out_ready <= !side_idles();
		end
	end

	task automatic add_cmd(logic cmd, int unsigned bytes, int unsigned offset, bit live);
		req_t r;
		r.command = cmd;
		r.request_bytes = 16'(bytes);
		r.release_offset = 15'(offset);
		pending_cmds.push_back(r);
		pending_live.push_back(live);
	endtask

	// Stimulus and end of run.
	initial begin
		int unsigned pick;
		blk_size[0] = SizeCap;
		used_units = 1;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero, tiny, unit edges, oversize, null and unaligned releases.
		add_cmd(CMD_ALLOC, 0, 15'h7fff, 0);
		add_cmd(CMD_ALLOC, 1, 0, 0);
		add_cmd(CMD_ALLOC, 8, 0, 0);
		add_cmd(CMD_ALLOC, 9, 0, 0);
		add_cmd(CMD_ALLOC, 32768, 0, 0);
		add_cmd(CMD_ALLOC, 65535, 0, 0);
		add_cmd(CMD_RELEASE, 16'hffff, 0, 0);
		add_cmd(CMD_RELEASE, 0, 7, 0);
		add_cmd(CMD_RELEASE, 0, 0, 1);
		add_cmd(CMD_ALLOC, 16000, 0, 0);
		add_cmd(CMD_ALLOC, 16000, 0, 0);
		// The heap is nearly full: no fitting block, then tail absorb.
		add_cmd(CMD_ALLOC, 400, 0, 0);
		add_cmd(CMD_ALLOC, 700, 0, 0);
		add_cmd(CMD_ALLOC, 8, 0, 0);
		add_cmd(CMD_RELEASE, 0, 0, 1);
		add_cmd(CMD_RELEASE, 0, 0, 1);
		add_cmd(CMD_RELEASE, 0, 0, 1);
		add_cmd(CMD_RELEASE, 0, 0, 1);
		add_cmd(CMD_RELEASE, 0, 0, 1);
		add_cmd(CMD_RELEASE, 0, 0, 1);
		add_cmd(CMD_ALLOC, 32760, 0, 0);
		add_cmd(CMD_RELEASE, 0, 0, 1);

		// Random: mostly allocations of modest size and releases of live blocks.
		repeat (118) begin
			pick = $urandom_range(99);
			if (pick < 45)
				add_cmd(CMD_ALLOC, $urandom_range(1, 512), $urandom, 0);
			else if (pick < 55)
				add_cmd(CMD_ALLOC, $urandom_range(0, 65535), $urandom, 0);
			else if (pick < 90)
				add_cmd(CMD_RELEASE, $urandom, 0, 1);
			else
				add_cmd(CMD_RELEASE, $urandom, $urandom_range(0, 7), 0);
		end

		wait (pending_cmds.size() == 0 && !in_valid && awaited_replies.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && awaited_replies.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
